### design/dltq_pkg.sv
// shared constants, codes and controller/datapath interface types for the timer queue
package dltq_pkg;

  localparam int unsigned MaxTimersDefault = 16;

  // field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned DurW   = 16;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned StatW  = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 64;
  localparam int unsigned EntryW = SeqW + DurW;

  // operation codes
  localparam logic [OpW-1:0] OP_ADD    = 2'd0;
  localparam logic [OpW-1:0] OP_CANCEL = 2'd1;
  localparam logic [OpW-1:0] OP_TICK   = 2'd2;

  // result status codes
  localparam logic [StatW-1:0] ST_HEAD      = 4'd0;
  localparam logic [StatW-1:0] ST_MID       = 4'd1;
  localparam logic [StatW-1:0] ST_TAIL      = 4'd2;
  localparam logic [StatW-1:0] ST_ZERO      = 4'd3;
  localparam logic [StatW-1:0] ST_FULL      = 4'd4;
  localparam logic [StatW-1:0] ST_NOTFOUND  = 4'd5;
  localparam logic [StatW-1:0] ST_EMPTY     = 4'd6;
  localparam logic [StatW-1:0] ST_RUNNING   = 4'd7;
  localparam logic [StatW-1:0] ST_EXPIRED   = 4'd8;
  localparam logic [StatW-1:0] ST_EXP_EMPTY = 4'd9;

  // index counter operations
  localparam logic [1:0] IDX_HOLD = 2'd0;
  localparam logic [1:0] IDX_INC  = 2'd1;
  localparam logic [1:0] IDX_DEC  = 2'd2;
  localparam logic [1:0] IDX_CNT  = 2'd3;

  // read address select
  localparam logic [1:0] RD_IDX = 2'd0;
  localparam logic [1:0] RD_DN  = 2'd1;
  localparam logic [1:0] RD_UP  = 2'd2;

  // write data select
  localparam logic [1:0] WR_NEW  = 2'd0;
  localparam logic [1:0] WR_UP   = 2'd1;
  localparam logic [1:0] WR_DN   = 2'd2;
  localparam logic [1:0] WR_TICK = 2'd3;

  typedef struct packed {
    logic             load;
    logic             clr;
    logic [1:0]       idx_op;
    logic             acc_add;
    logic             pos_ld;
    logic             del_ld;
    logic             exp_ld;
    logic             re;
    logic [1:0]       rsel;
    logic             we;
    logic [1:0]       wsel;
    logic             st_we;
    logic [StatW-1:0] st_code;
    logic             fin;
    logic             out_ld;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           dur_zero;
    logic           full;
    logic           empty;
    logic           idx_at_cnt;
    logic           idx_at_pos;
    logic           idx_last;
    logic           hit;
    logic           out_free;
  } sts_t;

endpackage

### design/dltq_ctrl.sv
// sequencer for scan, shift-up insert and shift-down removal of the timer queue
module dltq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  dltq_pkg::sts_t sts,
  output dltq_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCHK = 4'd3;
  localparam logic [3:0] S_UP   = 4'd4;
  localparam logic [3:0] S_UPW  = 4'd5;
  localparam logic [3:0] S_DN   = 4'd6;
  localparam logic [3:0] S_DNW  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.clr = 1'b1;
        case (sts.op) inside
          dltq_pkg::OP_ADD: begin
            if (sts.dur_zero) begin
              cmd.st_we = 1'b1; cmd.st_code = dltq_pkg::ST_ZERO; state_nxt = S_OUT;
            end else if (sts.full) begin
              cmd.st_we = 1'b1; cmd.st_code = dltq_pkg::ST_FULL; state_nxt = S_OUT;
            end else begin
              state_nxt = S_SRD;
            end
          end
          dltq_pkg::OP_CANCEL, dltq_pkg::OP_TICK: begin
            if (sts.empty) begin
              cmd.st_we = 1'b1; cmd.st_code = dltq_pkg::ST_EMPTY; state_nxt = S_OUT;
            end else begin
              state_nxt = S_SRD;
            end
          end
          default: begin
            cmd.st_we   = 1'b1;
            cmd.st_code = sts.empty ? dltq_pkg::ST_EMPTY : dltq_pkg::ST_RUNNING;
            state_nxt   = S_OUT;
          end
        endcase
      end
      S_SRD: begin
        if (sts.idx_at_cnt) begin
          if (sts.op == dltq_pkg::OP_ADD) begin
            cmd.pos_ld = 1'b1;
            state_nxt  = S_UP;
          end else begin
            cmd.st_we = 1'b1; cmd.st_code = dltq_pkg::ST_NOTFOUND; state_nxt = S_OUT;
          end
        end else begin
          cmd.re    = 1'b1;
          cmd.rsel  = dltq_pkg::RD_IDX;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        case (sts.op)
          dltq_pkg::OP_ADD: begin
            if (sts.hit) begin
              // insert point found, restart the walk from the tail
              cmd.pos_ld = 1'b1;
              cmd.idx_op = dltq_pkg::IDX_CNT;
              state_nxt  = S_UP;
            end else begin
              cmd.acc_add = 1'b1;
              cmd.idx_op  = dltq_pkg::IDX_INC;
              state_nxt   = S_SRD;
            end
          end
          dltq_pkg::OP_CANCEL: begin
            if (sts.hit) begin
              cmd.pos_ld = 1'b1;
              cmd.del_ld = 1'b1;
              state_nxt  = S_DN;
            end else begin
              cmd.idx_op = dltq_pkg::IDX_INC;
              state_nxt  = S_SRD;
            end
          end
          default: begin
            if (sts.hit) begin
              cmd.exp_ld = 1'b1;
              cmd.pos_ld = 1'b1;
              state_nxt  = S_DN;
            end else begin
              cmd.we      = 1'b1;
              cmd.wsel    = dltq_pkg::WR_TICK;
              cmd.st_we   = 1'b1;
              cmd.st_code = dltq_pkg::ST_RUNNING;
              state_nxt   = S_OUT;
            end
          end
        endcase
      end
      // open a slot by moving entries toward the tail
      S_UP: begin
        if (sts.idx_at_pos) begin
          cmd.we    = 1'b1;
          cmd.wsel  = dltq_pkg::WR_NEW;
          state_nxt = S_FIN;
        end else begin
          cmd.re    = 1'b1;
          cmd.rsel  = dltq_pkg::RD_UP;
          state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        cmd.we     = 1'b1;
        cmd.wsel   = dltq_pkg::WR_UP;
        cmd.idx_op = dltq_pkg::IDX_DEC;
        state_nxt  = S_UP;
      end
      // close the gap by moving entries toward the head
      S_DN: begin
        if (sts.idx_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.re    = 1'b1;
          cmd.rsel  = dltq_pkg::RD_DN;
          state_nxt = S_DNW;
        end
      end
      S_DNW: begin
        cmd.we     = 1'b1;
        cmd.wsel   = dltq_pkg::WR_DN;
        cmd.idx_op = dltq_pkg::IDX_INC;
        state_nxt  = S_DN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### design/dltq_datapath.sv
// entry memory, walk counters, delta arithmetic and result register of the timer queue
module dltq_datapath #(
  parameter int unsigned MAX_TIMERS = dltq_pkg::MaxTimersDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dltq_pkg::InTdataW-1:0]     in_tdata,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [dltq_pkg::OutTdataW-1:0]    out_tdata,
  input  dltq_pkg::cmd_t                    cmd,
  output dltq_pkg::sts_t                    sts
);

  localparam int unsigned IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CW = $clog2(MAX_TIMERS + 1);
  localparam int unsigned DW = dltq_pkg::DurW;
  localparam int unsigned SW = dltq_pkg::SeqW;

  logic [dltq_pkg::EntryW-1:0] mem [MAX_TIMERS];
  logic [dltq_pkg::EntryW-1:0] rdata_r;

  logic [dltq_pkg::OpW-1:0]   op_r;
  logic [DW-1:0]              dur_r, acc_r, del_r, head_r;
  logic [SW-1:0]              seq_r, exp_r;
  logic [CW-1:0]              cnt_r, idx_r, pos_r;
  logic [dltq_pkg::StatW-1:0] stat_r;
  logic                       out_valid_r;
  logic [dltq_pkg::OutTdataW-1:0] out_r;

  logic [DW-1:0]  rd_delta, new_delta, wdelta;
  logic [SW-1:0]  rd_seq, wseq;
  logic [DW:0]    scan_sum, fold_sum;
  logic [CW-1:0]  raddr, waddr, idx_p1, pos_p1;
  logic [CW+4:0]  cnt_ext;

  assign rd_delta  = rdata_r[DW-1:0];
  assign rd_seq    = rdata_r[dltq_pkg::EntryW-1:DW];
  assign new_delta = dur_r - acc_r;
  assign scan_sum  = {1'b0, acc_r} + {1'b0, rd_delta};
  assign fold_sum  = {1'b0, rd_delta} + {1'b0, del_r};
  assign idx_p1    = idx_r + CW'(1);
  assign pos_p1    = pos_r + CW'(1);

  // status toward the sequencer
  always_comb begin
    sts.op         = op_r;
    sts.dur_zero   = (dur_r == '0);
    sts.full       = (cnt_r == CW'(MAX_TIMERS));
    sts.empty      = (cnt_r == '0);
    sts.idx_at_cnt = (idx_r == cnt_r);
    sts.idx_at_pos = (idx_r == pos_r);
    sts.idx_last   = (idx_p1 == cnt_r);
    sts.out_free   = !out_valid_r || out_tready;
    case (op_r)
      dltq_pkg::OP_ADD:    sts.hit = (scan_sum > {1'b0, dur_r});
      dltq_pkg::OP_CANCEL: sts.hit = (rd_seq == seq_r);
      default:             sts.hit = (dur_r >= rd_delta);
    endcase
  end

  // read address
  always_comb begin
    case (cmd.rsel)
      dltq_pkg::RD_DN: raddr = idx_p1;
      dltq_pkg::RD_UP: raddr = idx_r - CW'(1);
      default:         raddr = idx_r;
    endcase
  end

  // write address and data
  always_comb begin
    waddr  = idx_r;
    wseq   = rd_seq;
    wdelta = rd_delta;
    case (cmd.wsel)
      dltq_pkg::WR_NEW: begin
        waddr  = pos_r;
        wseq   = seq_r;
        wdelta = new_delta;
      end
      dltq_pkg::WR_UP: begin
        if (idx_r == pos_p1) wdelta = rd_delta - new_delta;
      end
      dltq_pkg::WR_DN: begin
        if (idx_r == pos_r) wdelta = fold_sum[DW] ? {DW{1'b1}} : fold_sum[DW-1:0];
      end
      default: wdelta = rd_delta - dur_r;
    endcase
  end

  // entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.we) mem[waddr[IW-1:0]] <= {wseq, wdelta};
    if (cmd.re) rdata_r <= mem[raddr[IW-1:0]];
  end

  // command capture and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tdata[1:0];
      dur_r <= in_tdata[17:2];
      seq_r <= in_tdata[49:18];
      exp_r <= '0;
    end
    if (cmd.clr) begin
      acc_r <= '0;
      del_r <= '0;
      idx_r <= '0;
    end else begin
      case (cmd.idx_op)
        dltq_pkg::IDX_INC: idx_r <= idx_p1;
        dltq_pkg::IDX_DEC: idx_r <= idx_r - CW'(1);
        dltq_pkg::IDX_CNT: idx_r <= cnt_r;
        default:           idx_r <= idx_r;
      endcase
    end
    if (cmd.acc_add) acc_r <= scan_sum[DW-1:0];
    if (cmd.pos_ld)  pos_r <= idx_r;
    if (cmd.del_ld)  del_r <= rd_delta;
    if (cmd.exp_ld)  exp_r <= rd_seq;
    if (cmd.we && waddr == '0) head_r <= wdelta;
    if (cmd.st_we) stat_r <= cmd.st_code;
    if (cmd.fin) begin
      case (op_r)
        dltq_pkg::OP_ADD:
          stat_r <= (pos_r == '0) ? dltq_pkg::ST_HEAD :
                    (pos_r == cnt_r) ? dltq_pkg::ST_TAIL : dltq_pkg::ST_MID;
        dltq_pkg::OP_CANCEL:
          stat_r <= (pos_r == '0) ? dltq_pkg::ST_HEAD :
                    (pos_p1 == cnt_r) ? dltq_pkg::ST_TAIL : dltq_pkg::ST_MID;
        default:
          stat_r <= (cnt_r == CW'(1)) ? dltq_pkg::ST_EXP_EMPTY : dltq_pkg::ST_EXPIRED;
      endcase
    end
  end

  // queue occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.fin) begin
      cnt_r <= (op_r == dltq_pkg::OP_ADD) ? cnt_r + CW'(1) : cnt_r - CW'(1);
    end
  end

  assign cnt_ext = {5'b0, cnt_r};

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_r <= {7'b0, cnt_ext[4:0], (cnt_r != '0) ? head_r : {DW{1'b0}}, exp_r, stat_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

### design/delta_list_timer_queue_unit.sv
// top level of the delta-list timer queue
// timing: a reject goes straight from dispatch to the result state, a non-expiring tick
//   after reading the head entry; an add or cancel scans entries and then moves entries,
//   so its time grows with the number of entries scanned and moved
// throughput: one beat at a time, next accepted the cycle after its result is loaded;
//   a stalled result holds the input off
// reset: rst_n synchronous active low empties the queue and drops any pending result;
//   entry memory is not cleared, entries are written before they are read
module delta_list_timer_queue_unit #(
  parameter int unsigned MAX_TIMERS = dltq_pkg::MaxTimersDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // operation[1:0], duration[17:2], seq_no[49:18], zero pad
  input  logic [dltq_pkg::InTdataW-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[3:0], expired_seq[35:4], head_delta[51:36], timer_count[56:52], zero pad
  output logic [dltq_pkg::OutTdataW-1:0] out_tdata
);

  dltq_pkg::cmd_t cmd;
  dltq_pkg::sts_t sts;

  dltq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dltq_datapath #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### design/dltq_checker.sv
// port-level checks for the timer queue, bound to the top level
module dltq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [dltq_pkg::OutTdataW-1:0] out_tdata
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped under stall");

  // expired number only on expiry
  a_exp_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != dltq_pkg::ST_EXPIRED &&
    out_tdata[3:0] != dltq_pkg::ST_EXP_EMPTY |-> out_tdata[35:4] == '0)
    else $error("expired number without expiry");

  // an empty queue shows no head time
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[56:52] == '0 |-> out_tdata[51:36] == '0)
    else $error("head time on empty queue");

  // one command beat at a time
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command beat accepted back to back");

  // no result in the cycle after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

endmodule

bind delta_list_timer_queue_unit dltq_checker u_dltq_checker (.*);
